@@ hdl/xtea_pkg.sv @@
// Shared types, constants and helpers for the XTEA block cipher.
`timescale 1ns / 1ps

package xtea_pkg;

  localparam logic [31:0] XTEA_DELTA = 32'h9e37_79b9;

  // Upper limit on the XTEA round count; larger register values saturate to it.
  localparam int MAX_ROUNDS = 64;

  // Width of the round count register.
  localparam int ROUNDS_W = 7;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 7'd32;

  // Half-round counter holds up to twice the round count.
  localparam int HR_W = ROUNDS_W + 1;

  // Cells in the ring: one half-round each, phases alternate.
  localparam int NUM_CELLS = 2;

  localparam int PROD_W = ROUNDS_W + 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 3'd4;

  typedef logic [3:0][31:0] key_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] data_lo;
    logic [31:0] data_hi;
  } req_t;

  typedef struct packed {
    logic [31:0] result_lo;
    logic [31:0] result_hi;
  } rsp_t;

  // Settled configuration as seen by the datapath.
  typedef struct packed {
    key_t                key;
    logic [ROUNDS_W-1:0] rounds;   // already saturated
    logic [31:0]         dec_sum;  // delta * rounds, mod 2^32
  } cfg_t;

  // Token handed from cell to cell: a is the word updated next.
  typedef struct packed {
    logic        valid;
    logic        decrypt;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] sum;
  } token_t;

  function automatic logic [31:0] dec_start_sum(input logic [ROUNDS_W-1:0] n);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(XTEA_DELTA) * PROD_W'(n);
    return prod[31:0];
  endfunction

endpackage

@@ hdl/xtea_block_cipher.sv @@
// Top level of the XTEA block cipher: control, cell ring and result register.
`timescale 1ns / 1ps

// XTEA block cipher, one 64-bit block per command.
// Command: a transfer happens at a rising edge with start high and busy low;
// request carries req_type (0 encrypt, 1 decrypt), data_lo (v0), data_hi (v1).
// Result: result is valid for exactly one cycle while done is high; the
// receiver cannot stall it, so it must take the transfer in that cycle.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index 0..3 selects
// key words 0..3, index 4 the round count n (above 64 saturates to 64);
// other indexes are ignored. Write only while the block is idle.
// Datapath: a ring of two identical half-round cells; the token moves to
// the neighbouring cell every clock; one XTEA cycle is a pass through both.
// Timing: done is registered when the token has made its last half-round
// into the final cell; busy falls at that same edge, and the next command
// can transfer at the following edge, not before the last block is done.
// With n of 0 the block passes through: done rises at the transfer edge
// itself and busy stays low, so such commands can follow back to back.
// Reset: key words clear to zero, n returns to 32, ring and done clear.
module xtea_block_cipher (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  xtea_pkg::req_t                  request,
  output logic                            done,
  output xtea_pkg::rsp_t                  result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);

  xtea_pkg::cfg_t                   cfg;
  xtea_pkg::token_t                 ring [xtea_pkg::NUM_CELLS];
  xtea_pkg::token_t                 feed;
  xtea_pkg::token_t                 fresh;
  xtea_pkg::token_t                 last;
  logic [xtea_pkg::HR_W-1:0]        hr_left;
  logic                             accept;
  logic                             bypass;
  logic                             finish;

  xtea_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign accept = start && !busy;
  assign bypass = (cfg.rounds == '0);
  assign last   = ring[xtea_pkg::NUM_CELLS-1];
  // last half-round done, token sits in the final cell
  assign finish = busy && last.valid && (hr_left == '0);

  // New token: for decrypt the first word updated is v1
  always_comb begin
    fresh.valid   = 1'b1;
    fresh.decrypt = request.req_type;
    fresh.a       = request.req_type ? request.data_hi : request.data_lo;
    fresh.b       = request.req_type ? request.data_lo : request.data_hi;
    fresh.sum     = request.req_type ? cfg.dec_sum : 32'd0;
  end

  always_comb begin
    feed       = last;
    feed.valid = busy && last.valid && (hr_left != '0);
    if (accept && !bypass) begin
      feed = fresh;
    end
  end

  for (genvar i = 0; i < xtea_pkg::NUM_CELLS; i++) begin : g_cell
    xtea_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .phase   (1'(i % 2)),
      .key     (cfg.key),
      .tok_in  ((i == 0) ? feed : ring[(i == 0) ? 0 : i - 1]),
      .tok_out (ring[i])
    );
  end

  // Control: busy, done strobe and half-round count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      hr_left <= '0;
      done    <= 1'b0;
    end else begin
      done <= finish || (accept && bypass);
      if (accept && !bypass) begin
        busy    <= 1'b1;
        // the transfer edge already runs the first half-round
        hr_left <= {cfg.rounds, 1'b0} - xtea_pkg::HR_W'(1);
      end else begin
        if (finish) begin
          busy <= 1'b0;
        end
        if (busy && (hr_left != '0)) begin
          hr_left <= hr_left - xtea_pkg::HR_W'(1);
        end
      end
    end
  end

  // Result register; words swap back for decrypt, pass-through loads as is
  always_ff @(posedge clk) begin
    if (finish) begin
      result.result_lo <= last.decrypt ? last.b : last.a;
      result.result_hi <= last.decrypt ? last.a : last.b;
    end else if (accept && bypass) begin
      result.result_lo <= request.data_lo;
      result.result_hi <= request.data_hi;
    end
  end

endmodule

@@ hdl/xtea_cell.sv @@
// One XTEA half-round cell of the ring, registered output.
`timescale 1ns / 1ps

module xtea_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              phase,
  input  xtea_pkg::key_t    key,
  input  xtea_pkg::token_t  tok_in,
  output xtea_pkg::token_t  tok_out
);

  logic [31:0]      mix;
  logic [1:0]       kidx;
  logic [31:0]      f;
  logic [31:0]      a_new;
  logic [31:0]      sum_new;
  xtea_pkg::token_t tok_next;

  always_comb begin
    mix  = ((tok_in.b << 4) ^ (tok_in.b >> 5)) + tok_in.b;
    // second half of an encrypt cycle, or first half of a decrypt one,
    // picks the key from sum bits 12:11
    kidx = (phase ^ tok_in.decrypt) ? tok_in.sum[12:11] : tok_in.sum[1:0];
    f    = mix ^ (tok_in.sum + key[kidx]);
    a_new = tok_in.decrypt ? (tok_in.a - f) : (tok_in.a + f);
    if (phase) begin
      sum_new = tok_in.sum;
    end else if (tok_in.decrypt) begin
      sum_new = tok_in.sum - xtea_pkg::XTEA_DELTA;
    end else begin
      sum_new = tok_in.sum + xtea_pkg::XTEA_DELTA;
    end
    tok_next.valid   = tok_in.valid;
    tok_next.decrypt = tok_in.decrypt;
    tok_next.a       = tok_in.b;  // words swap so the next cell updates the other one
    tok_next.b       = a_new;
    tok_next.sum     = sum_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ hdl/xtea_cfg.sv @@
// Configuration registers: key words and saturated round count.
`timescale 1ns / 1ps

module xtea_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data,
  output xtea_pkg::cfg_t                   cfg
);

  logic [xtea_pkg::ROUNDS_W-1:0] rounds_sat;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (32'(cfg_data[xtea_pkg::ROUNDS_W-1:0]) > xtea_pkg::MAX_ROUNDS) begin
      rounds_sat = xtea_pkg::ROUNDS_W'(xtea_pkg::MAX_ROUNDS);
    end else begin
      rounds_sat = cfg_data[xtea_pkg::ROUNDS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key     <= '0;
      cfg.rounds  <= xtea_pkg::ROUNDS_RESET;
      cfg.dec_sum <= xtea_pkg::dec_start_sum(xtea_pkg::ROUNDS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        xtea_pkg::REG_KEY0, xtea_pkg::REG_KEY1,
        xtea_pkg::REG_KEY2, xtea_pkg::REG_KEY3: begin
          cfg.key[cfg_index[1:0]] <= cfg_data;
        end
        xtea_pkg::REG_ROUNDS: begin
          cfg.rounds  <= rounds_sat;
          cfg.dec_sum <= xtea_pkg::dec_start_sum(rounds_sat);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/xtea_checker.sv @@
// Port-level checks for the XTEA block cipher, bound to the top level.
`timescale 1ns / 1ps

module xtea_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // result strobe only once the engine has let go
  a_done_not_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // an accepted command either starts work or completes at once
  a_accept_progress : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("command transfer without progress");

  // busy only ends by delivering a result
  a_busy_ends_done : assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without result");

  a_reset_idle : assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("not idle after reset");

endmodule

bind xtea_block_cipher xtea_checker u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

@@ tb/sv/xtea_block_cipher_tb.sv @@
// Self-checking testbench for the XTEA block cipher: directed table, then random phases.
`timescale 1ns / 1ps

// What is covered:
//  - command transfers (start/busy) with random gaps, back-to-back commands
//    and occasional pauses until the ring has drained;
//  - every result strobe is checked field by field against a local XTEA
//    model (key words and round count as written) or a row's known value;
//  - config writes only while idle; all five registers plus the unused
//    indexes (which must be ignored), with junk in the upper bits of the
//    round count write;
//  - round counts of zero (pass-through), one, 64, and above 64 (saturates
//    for both the cycle count and the decrypt start sum).
module xtea_block_cipher_tb;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam int NUM_DIRECTED = 17;
  localparam int NUM_RANDOM   = 700;
  localparam int NUM_CFG_IDX  = 2 ** xtea_pkg::CFG_IDX_W;

  localparam xtea_pkg::key_t KEY_ZERO = '0;
  localparam xtea_pkg::key_t KEY_ONES = '1;
  localparam xtea_pkg::key_t KEY_SEQ  =
    {32'h0f0e_0d0c, 32'h0b0a_0908, 32'h0706_0504, 32'h0302_0100};
  localparam xtea_pkg::key_t KEY_ALT  =
    {32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'hffff_0000, 32'h0000_ffff};

  // One row of the directed table. A row with reconfig set drains the block
  // and loads key and rounds first; exp is only meaningful where known is set.
  typedef struct packed {
    logic                          reconfig;
    xtea_pkg::key_t                key;
    logic [xtea_pkg::ROUNDS_W-1:0] rounds;
    xtea_pkg::req_t                req;
    logic                          known;
    xtea_pkg::rsp_t                exp;
  } vec_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  xtea_pkg::req_t                 request = '0;
  logic                           done;
  xtea_pkg::rsp_t                 result;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                    cfg_data = '0;

  // Shadow of the programmed registers, as the block should see them.
  xtea_pkg::key_t                key_words = KEY_ZERO;
  logic [xtea_pkg::ROUNDS_W-1:0] round_cnt = xtea_pkg::ROUNDS_RESET;

  xtea_pkg::rsp_t blocks_in_flight [$];
  int             errors = 0;

  xtea_block_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Cipher model
  // ---------------------------------------------------------------------
  function automatic logic [31:0] feistel_mix(logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  function automatic xtea_pkg::rsp_t xtea_cipher(xtea_pkg::req_t r);
    logic [31:0]    v0;
    logic [31:0]    v1;
    logic [31:0]    s;
    int             n;
    xtea_pkg::rsp_t o;
    v0 = r.data_lo;
    v1 = r.data_hi;
    // register values above the limit saturate
    n = (int'(round_cnt) > xtea_pkg::MAX_ROUNDS) ? xtea_pkg::MAX_ROUNDS : int'(round_cnt);
    if (r.req_type == OP_ENCRYPT) begin
      s = '0;
      for (int i = 0; i < n; i++) begin
        v0 = v0 + (feistel_mix(v1) ^ (s + key_words[s[1:0]]));
        s  = s + xtea_pkg::XTEA_DELTA;
        v1 = v1 + (feistel_mix(v0) ^ (s + key_words[s[12:11]]));
      end
    end else begin
      s = xtea_pkg::XTEA_DELTA * 32'(n);
      for (int i = 0; i < n; i++) begin
        v1 = v1 - (feistel_mix(v0) ^ (s + key_words[s[12:11]]));
        s  = s - xtea_pkg::XTEA_DELTA;
        v0 = v0 - (feistel_mix(v1) ^ (s + key_words[s[1:0]]));
      end
    end
    o.result_lo = v0;
    o.result_hi = v1;
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so look at every strobe
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    xtea_pkg::rsp_t want;
    if (!rst && done) begin
      if (blocks_in_flight.size() == 0) begin
        $error("result strobe with no block in flight: lo %h hi %h",
               result.result_lo, result.result_hi);
        errors++;
      end else begin
        want = blocks_in_flight.pop_front();
        if (result.result_lo !== want.result_lo) begin
          $error("result_lo: expected %h, got %h", want.result_lo, result.result_lo);
          errors++;
        end
        if (result.result_hi !== want.result_hi) begin
          $error("result_hi: expected %h, got %h", want.result_hi, result.result_hi);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------

  // Wait for every block to come back, then a few more cycles of slack.
  task automatic drain_blocks();
    while (blocks_in_flight.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One config transfer; cfg_valid is left high so writes can run back to back.
  task automatic cfg_write(logic [xtea_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= xtea_pkg::REG_KEY3)
      key_words[idx[1:0]] = data;
    else if (idx == xtea_pkg::REG_ROUNDS)
      round_cnt = data[xtea_pkg::ROUNDS_W-1:0];
  endtask

  // Full register load while idle. Unused indexes go last, so that an
  // aliased decode would clobber a live register and show up.
  task automatic load_settings(xtea_pkg::key_t k, logic [xtea_pkg::ROUNDS_W-1:0] n);
    drain_blocks();
    cfg_write(xtea_pkg::REG_KEY0, k[0]);
    cfg_write(xtea_pkg::REG_KEY1, k[1]);
    cfg_write(xtea_pkg::REG_KEY2, k[2]);
    cfg_write(xtea_pkg::REG_KEY3, k[3]);
    // upper bits of the round count write are don't-care
    cfg_write(xtea_pkg::REG_ROUNDS, ($urandom & ~32'h7f) | 32'(n));
    for (int i = int'(xtea_pkg::REG_ROUNDS) + 1; i < NUM_CFG_IDX; i++)
      cfg_write(xtea_pkg::CFG_IDX_W'(i), $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Present one block and hold it until the command transfer happens.
  task automatic send_block(xtea_pkg::req_t r, logic known, xtea_pkg::rsp_t exp);
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    blocks_in_flight.push_back(known ? exp : xtea_cipher(r));
  endtask

  // Idle after a transfer. start stays high only for a back-to-back command.
  task automatic idle_after(int gap, logic last, logic pause);
    if (gap > 0 || last || pause)
      start <= 1'b0;
    if (pause)
      drain_blocks();
    repeat (gap) @(posedge clk);
  endtask

  function automatic int pick_gap(logic quiet);
    int r;
    r = $urandom_range(0, 9);
    if (quiet || r < 6)
      return 0;
    else if (r < 9)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_t row(logic reconfig, xtea_pkg::key_t k,
                               logic [xtea_pkg::ROUNDS_W-1:0] n, logic op,
                               logic [31:0] lo, logic [31:0] hi, logic known,
                               logic [31:0] exp_lo, logic [31:0] exp_hi);
    vec_t v;
    v.reconfig      = reconfig;
    v.key           = k;
    v.rounds        = n;
    v.req.req_type  = op;
    v.req.data_lo   = lo;
    v.req.data_hi   = hi;
    v.known         = known;
    v.exp.result_lo = exp_lo;
    v.exp.result_hi = exp_hi;
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    vec_t                          directed [NUM_DIRECTED];
    xtea_pkg::req_t                r;
    xtea_pkg::key_t                k;
    logic [xtea_pkg::ROUNDS_W-1:0] n;
    logic                          quiet;
    logic                          last;
    int                            burst;
    int                            sent;
    int                            waited;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset values first, then the extremes of the round count.
    directed = '{
      row(1'b0, KEY_ZERO, 7'd0,   OP_ENCRYPT, 32'h0,         32'h0,         1'b0, '0, '0),
      row(1'b0, KEY_ZERO, 7'd0,   OP_DECRYPT, 32'h0,         32'h0,         1'b0, '0, '0),
      row(1'b0, KEY_ZERO, 7'd0,   OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0, '0),
      row(1'b0, KEY_ZERO, 7'd0,   OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0, '0),
      // zero cycles: block passes straight through
      row(1'b1, KEY_ONES, 7'd0,   OP_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef,
          1'b1, 32'h0123_4567, 32'h89ab_cdef),
      row(1'b0, KEY_ONES, 7'd0,   OP_DECRYPT, 32'hffff_ffff, 32'h0,
          1'b1, 32'hffff_ffff, 32'h0),
      row(1'b1, KEY_ONES, 7'd1,   OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0, '0),
      row(1'b0, KEY_ONES, 7'd1,   OP_DECRYPT, 32'h0,         32'h0,         1'b0, '0, '0),
      row(1'b1, KEY_SEQ,  7'd64,  OP_ENCRYPT, 32'h4142_4344, 32'h4546_4748, 1'b0, '0, '0),
      row(1'b0, KEY_SEQ,  7'd64,  OP_DECRYPT, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, '0, '0),
      // above the limit: saturates, including the decrypt start sum
      row(1'b1, KEY_ALT,  7'd65,  OP_ENCRYPT, 32'h0,         32'hffff_ffff, 1'b0, '0, '0),
      row(1'b0, KEY_ALT,  7'd65,  OP_DECRYPT, 32'hffff_ffff, 32'h0,         1'b0, '0, '0),
      row(1'b1, KEY_SEQ,  7'd127, OP_ENCRYPT, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0, '0),
      row(1'b0, KEY_SEQ,  7'd127, OP_DECRYPT, 32'h0,         32'h0,         1'b0, '0, '0),
      row(1'b1, KEY_SEQ,  7'd32,  OP_ENCRYPT, 32'h4142_4344, 32'h4546_4748, 1'b0, '0, '0),
      row(1'b0, KEY_SEQ,  7'd32,  OP_DECRYPT, 32'h1234_5678, 32'h9abc_def0, 1'b0, '0, '0),
      row(1'b1, KEY_ZERO, 7'd32,  OP_ENCRYPT, 32'hffff_ffff, 32'h0,         1'b0, '0, '0)
    };

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed[i].reconfig)
        load_settings(directed[i].key, directed[i].rounds);
      send_block(directed[i].req, directed[i].known, directed[i].exp);
      last = (i == NUM_DIRECTED - 1) || directed[(i + 1) % NUM_DIRECTED].reconfig;
      idle_after(0, last, 1'b0);
    end

    // Random phases: fresh settings each time, then a burst of blocks.
    sent = 0;
    while (sent < NUM_RANDOM) begin
      case ($urandom_range(0, 5))
        0:       k = KEY_ZERO;
        1:       k = KEY_ONES;
        default: k = {$urandom, $urandom, $urandom, $urandom};
      endcase
      case ($urandom_range(0, 9))
        0:       n = 7'd0;
        1:       n = 7'd1;
        2:       n = 7'd64;
        3:       n = xtea_pkg::ROUNDS_W'($urandom_range(65, 127));
        4:       n = 7'd127;
        5:       n = xtea_pkg::ROUNDS_RESET;
        default: n = xtea_pkg::ROUNDS_W'($urandom_range(1, 64));
      endcase
      load_settings(k, n);
      quiet = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(40, 100);
      for (int j = 0; j < burst && sent < NUM_RANDOM; j++) begin
        r.req_type = $urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT;
        r.data_lo  = pick_word();
        r.data_hi  = pick_word();
        send_block(r, 1'b0, '0);
        sent++;
        last = (j == burst - 1) || (sent == NUM_RANDOM);
        // one hold-off per phase on average: let the ring empty out
        idle_after(pick_gap(quiet), last, $urandom_range(0, 59) == 0);
      end
    end

    // Bounded wait for the tail, then some slack for a stray strobe.
    waited = 0;
    while (blocks_in_flight.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);

    if (errors == 0 && blocks_in_flight.size() == 0) begin
      $display("PASS");
    end else begin
      if (blocks_in_flight.size() != 0)
        $error("%0d block(s) never came back", blocks_in_flight.size());
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ xtea_block_cipher.f @@
hdl/xtea_pkg.sv
hdl/xtea_cell.sv
hdl/xtea_cfg.sv
hdl/xtea_block_cipher.sv
hdl/xtea_checker.sv
tb/sv/xtea_block_cipher_tb.sv
